### hw/rtl/kls_pkg.sv
// kls_pkg: shared types, constants and helpers for the keyframe loop light sampler.
// No dependencies.
package kls_pkg;

    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int PHASE_W  = 10;
    localparam int KEY_W    = 8;
    localparam int SWEEP_W  = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLECTION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT      = 3'd4;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd4000;
    localparam logic [PHASE_W:0]    PHASE_HALF   = 11'd512;
    localparam logic [PHASE_W:0]    PHASE_FULL   = 11'd1024;

    typedef logic [KEY_W-1:0] key_t;

    // floor(x / 255), exact for x < 65535
    function automatic logic [8:0] div255(input logic [16:0] x);
        logic [17:0] t;
        t = {1'b0, x} + {9'd0, x[16:8]} + 18'd1;
        return t[16:8];
    endfunction

    function automatic key_t key_sel(input logic [4*KEY_W-1:0] keys, input logic [1:0] idx);
        return keys[idx*KEY_W +: KEY_W];
    endfunction

endpackage

### hw/rtl/keyframe_loop_light_sampler.sv
// keyframe_loop_light_sampler: top level, config registers and post-divide stages.
// Uses kls_pkg and kls_phase_div.
//
// channel   signals                                     handshake
// input     start, busy, now_ms                         start & !busy
// result    done, energy, reflection, drift_x, beat,    done, one cycle
//           blend, sweep
// config    cfg_valid, cfg_ready, cfg_index, cfg_data   cfg_valid & cfg_ready
//
// One item per cycle; busy is always low. The offset-add stage feeds the divider,
// which runs the 42-step restoring division three steps per stage.
// Reset clears valid bits and loads register defaults. The receiver cannot
// stall, so the pipeline never holds.
module keyframe_loop_light_sampler #(
    parameter int CELL_PX = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [kls_pkg::TIME_W-1:0]          now_ms,
    output logic                                done,
    output logic [7:0]                          energy,
    output logic [7:0]                          reflection,
    output logic signed [7:0]                   drift_x,
    output logic [1:0]                          beat,
    output logic [7:0]                          blend,
    output logic [kls_pkg::SWEEP_W-1:0]         sweep,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kls_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kls_pkg::CFG_DATA_W-1:0]      cfg_data
);
    localparam int HALF_Q8 = (CELL_PX * 255) / 2;
    localparam int RECIP   = 65536 / CELL_PX + 1;

    logic [15:0] period_reg, offset_reg;
    logic [31:0] energy_keys_reg, refl_keys_reg, drift_keys_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg      <= kls_pkg::PERIOD_RESET;
            offset_reg      <= '0;
            energy_keys_reg <= '0;
            refl_keys_reg   <= '0;
            drift_keys_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                kls_pkg::CFG_PERIOD:     period_reg      <= cfg_data[15:0];
                kls_pkg::CFG_OFFSET:     offset_reg      <= cfg_data[15:0];
                kls_pkg::CFG_ENERGY:     energy_keys_reg <= cfg_data;
                kls_pkg::CFG_REFLECTION: refl_keys_reg   <= cfg_data;
                kls_pkg::CFG_DRIFT:      drift_keys_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: offset add
    logic        s0_vld_reg;
    logic [31:0] s0_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else
            s0_vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s0_sum_reg <= now_ms + {16'd0, offset_reg};
    end

    logic       dv_vld;
    logic [9:0] dv_q10;

    kls_phase_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (s0_vld_reg),
        .sum     (s0_sum_reg),
        .period  (period_reg),
        .out_vld (dv_vld),
        .q10     (dv_q10)
    );

    // stage 1: key select and products
    logic [9:0] q10;
    logic [1:0] bt, nx;
    logic [7:0] fr;
    kls_pkg::key_t ea, eb, ra, rb, da, db;
    logic signed [17:0] e_prod_next, r_prod_next, dq8_next;
    logic [8:0] sweep_next;

    assign q10 = (period_reg == '0) ? '0 : dv_q10;
    assign bt  = q10[9:8];
    assign nx  = bt + 2'd1;
    assign fr  = q10[7:0];

    always_comb
    begin
        ea = kls_pkg::key_sel(energy_keys_reg, bt);
        eb = kls_pkg::key_sel(energy_keys_reg, nx);
        ra = kls_pkg::key_sel(refl_keys_reg, bt);
        rb = kls_pkg::key_sel(refl_keys_reg, nx);
        da = kls_pkg::key_sel(drift_keys_reg, bt);
        db = kls_pkg::key_sel(drift_keys_reg, nx);
        e_prod_next = ($signed({1'b0, eb}) - $signed({1'b0, ea})) * $signed({1'b0, fr});
        r_prod_next = ($signed({1'b0, rb}) - $signed({1'b0, ra})) * $signed({1'b0, fr});
        dq8_next = $signed({{10{da[7]}}, da}) * 18'sd255
                 + ($signed({db[7], db}) - $signed({da[7], da})) * $signed({1'b0, fr});
        if ({1'b0, q10} <= kls_pkg::PHASE_HALF)
            sweep_next = q10[9:1];
        else
            sweep_next = 9'((kls_pkg::PHASE_FULL - {1'b0, q10}) >> 1);
    end

    logic               s1_vld_reg;
    logic [1:0]         s1_beat_reg;
    logic [7:0]         s1_blend_reg, s1_ea_reg, s1_ra_reg;
    logic [8:0]         s1_sweep_reg;
    logic signed [17:0] s1_e_reg, s1_r_reg, s1_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        s1_beat_reg  <= bt;
        s1_blend_reg <= fr;
        s1_sweep_reg <= sweep_next;
        s1_ea_reg    <= ea;
        s1_ra_reg    <= ra;
        s1_e_reg     <= e_prod_next;
        s1_r_reg     <= r_prod_next;
        s1_d_reg     <= dq8_next;
    end

    // stage 2: divide by 255
    logic [16:0] e_mag, r_mag, d_mag;
    logic [8:0]  e_q, r_q, d_y_next;
    logic [7:0]  e_next, r_next;

    always_comb
    begin
        e_mag = s1_e_reg[17] ? 17'(-s1_e_reg) : s1_e_reg[16:0];
        r_mag = s1_r_reg[17] ? 17'(-s1_r_reg) : s1_r_reg[16:0];
        d_mag = s1_d_reg[17] ? 17'(-s1_d_reg) : s1_d_reg[16:0];
        e_q = kls_pkg::div255(e_mag);
        r_q = kls_pkg::div255(r_mag);
        d_y_next = kls_pkg::div255(d_mag + 17'(HALF_Q8));
        e_next = s1_e_reg[17] ? s1_ea_reg - e_q[7:0] : s1_ea_reg + e_q[7:0];
        r_next = s1_r_reg[17] ? s1_ra_reg - r_q[7:0] : s1_ra_reg + r_q[7:0];
    end

    logic       s2_vld_reg, s2_neg_reg;
    logic [1:0] s2_beat_reg;
    logic [7:0] s2_blend_reg, s2_e_reg, s2_r_reg;
    logic [8:0] s2_sweep_reg, s2_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_beat_reg  <= s1_beat_reg;
        s2_blend_reg <= s1_blend_reg;
        s2_sweep_reg <= s1_sweep_reg;
        s2_e_reg     <= e_next;
        s2_r_reg     <= r_next;
        s2_y_reg     <= d_y_next;
        s2_neg_reg   <= s1_d_reg[17];
    end

    // stage 3: divide by cell size, snap back to pixels
    logic [25:0] c_prod;
    logic [7:0]  cells;
    logic [12:0] px;
    logic [7:0]  drift_next;

    always_comb
    begin
        c_prod = 26'({17'd0, s2_y_reg} * 26'(RECIP));
        cells  = c_prod[23:16];
        px     = 13'({5'd0, cells} * 13'(CELL_PX));
        drift_next = s2_neg_reg ? 8'(-px[7:0]) : px[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        energy     <= s2_e_reg;
        reflection <= s2_r_reg;
        drift_x    <= $signed(drift_next);
        beat       <= s2_beat_reg;
        blend      <= s2_blend_reg;
        sweep      <= s2_sweep_reg;
    end

endmodule

### hw/rtl/kls_phase_div.sv
// kls_phase_div: pipelined restoring divider giving the Q10 loop phase
// floor(((sum mod period) * 1024) / period). Uses kls_pkg.
module kls_phase_div #(
    parameter int STEPS = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_vld,
    input  logic [kls_pkg::TIME_W-1:0]      sum,
    input  logic [kls_pkg::PERIOD_W-1:0]    period,
    output logic                            out_vld,
    output logic [kls_pkg::PHASE_W-1:0]     q10
);
    localparam int DVD_W  = kls_pkg::TIME_W + kls_pkg::PHASE_W;
    localparam int STAGES = (DVD_W + STEPS - 1) / STEPS;
    localparam int PW     = kls_pkg::PERIOD_W;
    localparam int QW     = kls_pkg::PHASE_W;

    logic          vld_reg [0:STAGES];
    logic [PW-1:0] rem_reg [0:STAGES];
    logic [DVD_W-1:0] dvd_reg [0:STAGES];
    logic [QW-1:0] q_reg   [0:STAGES];

    assign vld_reg[0] = in_vld;
    assign rem_reg[0] = '0;
    assign dvd_reg[0] = {sum, {QW{1'b0}}};
    assign q_reg[0]   = '0;

    genvar g;
    generate
        for (g = 0; g < STAGES; g++)
        begin : g_stage
            logic [PW-1:0]    rem_next;
            logic [DVD_W-1:0] dvd_next;
            logic [QW-1:0]    q_next;

            always_comb
            begin
                logic [PW:0] t;
                rem_next = rem_reg[g];
                dvd_next = dvd_reg[g];
                q_next   = q_reg[g];
                for (int i = 0; i < STEPS; i++)
                begin
                    if (g * STEPS + i < DVD_W)
                    begin
                        t = {rem_next, dvd_next[DVD_W-1]};
                        dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
                        if (t >= {1'b0, period})
                        begin
                            t = t - {1'b0, period};
                            q_next = {q_next[QW-2:0], 1'b1};
                        end
                        else
                        begin
                            q_next = {q_next[QW-2:0], 1'b0};
                        end
                        rem_next = t[PW-1:0];
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g+1] <= 1'b0;
                end
                else
                begin
                    vld_reg[g+1] <= vld_reg[g];
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[g+1] <= rem_next;
                dvd_reg[g+1] <= dvd_next;
                q_reg[g+1]   <= q_next;
            end
        end
    endgenerate

    assign out_vld = vld_reg[STAGES];
    assign q10     = q_reg[STAGES];

endmodule
